// ===== rtl/cgrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgrm_pkg
// Shared widths, codes and control types for the calibrated gas ratio meter.
// ----------------------------------------------------------------------------
package cgrm_pkg;

  localparam int WINDOW   = 5;
  localparam int SAMPLE_W = 16;
  localparam int CMD_W    = 2;
  localparam int REF_W    = 10;
  localparam int CAL_W    = 16;
  localparam int PCT_W    = 16;
  localparam int LVL_W    = 16;

  localparam logic [REF_W-1:0] REF_RESET = 10'd209;

  localparam int SUM_W  = $clog2(WINDOW) + SAMPLE_W;
  localparam int MAG_W  = SUM_W;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MREF_W = MAG_W + REF_W;
  localparam int NUM_W  = MREF_W + 4;
  localparam int DEN_W  = CNT_W + CAL_W;
  localparam int SAT_W  = (NUM_W > DEN_W + PCT_W) ? NUM_W : DEN_W + PCT_W;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int LOW_W  = SUM_W + 6;

  // 0.05 mV at 1/128 mV per code is 6.4 codes: 5*|sum| < 32*count
  localparam int LOW_MAG_MUL = 5;
  localparam int LOW_CNT_MUL = 32;
  localparam int PCT_SCALE   = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_MEASURE   = 2'd0,
    CMD_CALIBRATE = 2'd1,
    CMD_LOAD      = 2'd2
  } cmd_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_LVL_LOAD,
    S_LVL_RUN,
    S_CAL,
    S_PROD,
    S_CHECK,
    S_PCT_RUN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic lvl_start;
    logic lvl_take;
    logic cal_step;
    logic prod_step;
    logic pct_check;
    logic pct_take;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic lvl_div;
    logic pct_div;
  } dp_sts_t;

endpackage

// ===== rtl/cgrm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgrm_div
// Bit-serial restoring divider, one quotient bit per cycle, preloadable
// partial remainder and step count.
// ----------------------------------------------------------------------------
module cgrm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ld,
  input  logic [cgrm_pkg::NUM_W-1:0]    dvd_in,
  input  logic [cgrm_pkg::DEN_W-1:0]    rem_in,
  input  logic [cgrm_pkg::DEN_W-1:0]    dsr_in,
  input  logic [cgrm_pkg::STEP_W-1:0]   steps,
  output logic                          busy,
  output logic [cgrm_pkg::NUM_W-1:0]    quo
);

  logic [cgrm_pkg::NUM_W-1:0]  dvd_r, dvd_nxt;
  logic [cgrm_pkg::DEN_W-1:0]  rem_r, rem_nxt;
  logic [cgrm_pkg::DEN_W-1:0]  dsr_r;
  logic [cgrm_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic [cgrm_pkg::DEN_W:0]    rem_sh;
  logic [cgrm_pkg::DEN_W:0]    rem_sub;
  logic                        ge;

  assign rem_sh  = {rem_r, dvd_r[cgrm_pkg::NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign ge      = (rem_sh >= {1'b0, dsr_r});

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ld) begin
      dvd_nxt  = dvd_in;
      rem_nxt  = rem_in;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[cgrm_pkg::NUM_W-2:0], ge};
      rem_nxt  = ge ? rem_sub[cgrm_pkg::DEN_W-1:0] : rem_sh[cgrm_pkg::DEN_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != cgrm_pkg::STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (ld) begin
      dsr_r <= dsr_in;
    end
  end

  assign busy = busy_r;
  assign quo  = dvd_r;

endmodule

// ===== rtl/cgrm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgrm_dp
// Datapath: sample window and running sum, calibration, products, shared
// divider and result registers.
// ----------------------------------------------------------------------------
module cgrm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cgrm_pkg::ctrl_cmd_t             cmd,
  output cgrm_pkg::dp_sts_t               sts,
  input  logic [cgrm_pkg::CMD_W-1:0]      in_cmd,
  input  logic [cgrm_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                            cfg_wr_en,
  input  logic [cgrm_pkg::REF_W-1:0]      cfg_wr_data,
  output logic [cgrm_pkg::PCT_W-1:0]      out_pct,
  output logic [cgrm_pkg::LVL_W-1:0]      out_lvl,
  output logic                            out_low,
  output logic                            out_uncal,
  output logic                            out_clip
);

  logic [cgrm_pkg::REF_W-1:0]           ref_r;
  logic [cgrm_pkg::CMD_W-1:0]           cmd_r;
  logic signed [cgrm_pkg::SAMPLE_W-1:0] smp_r;
  logic signed [cgrm_pkg::SAMPLE_W-1:0] win_r [cgrm_pkg::WINDOW];
  logic [cgrm_pkg::SLOT_W-1:0]          slot_r, slot_nxt;
  logic [cgrm_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic signed [cgrm_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [cgrm_pkg::CAL_W-1:0]           cal_r, cal_nxt;
  logic [cgrm_pkg::MAG_W-1:0]           mag_r, mag_nxt;
  logic [cgrm_pkg::LVL_W-1:0]           lvl_r;
  logic [cgrm_pkg::MREF_W-1:0]          mref_r;
  logic [cgrm_pkg::NUM_W-1:0]           num_r;
  logic [cgrm_pkg::DEN_W-1:0]           den_r;
  logic [cgrm_pkg::PCT_W-1:0]           pct_r;
  logic                                 low_r;
  logic                                 clip_r;
  logic [cgrm_pkg::PCT_W-1:0]           out_pct_r;
  logic [cgrm_pkg::LVL_W-1:0]           out_lvl_r;
  logic                                 out_low_r;
  logic                                 out_uncal_r;
  logic                                 out_clip_r;

  logic signed [cgrm_pkg::SAMPLE_W-1:0] old_smp;
  logic [cgrm_pkg::CAL_W-1:0]           smp_abs;
  logic                                 cnt_full;
  logic                                 sat;
  logic                                 div_ld;
  logic [cgrm_pkg::NUM_W-1:0]           div_dvd;
  logic [cgrm_pkg::DEN_W-1:0]           div_rem;
  logic [cgrm_pkg::DEN_W-1:0]           div_dsr;
  logic [cgrm_pkg::STEP_W-1:0]          div_steps;
  logic                                 div_busy;
  logic [cgrm_pkg::NUM_W-1:0]           div_quo;

  assign cnt_full = (cnt_r == cgrm_pkg::CNT_W'(cgrm_pkg::WINDOW));
  assign old_smp  = cnt_full ? win_r[slot_r] : '0;
  assign smp_abs  = smp_r[cgrm_pkg::SAMPLE_W-1] ? cgrm_pkg::CAL_W'(-smp_r)
                                                 : cgrm_pkg::CAL_W'(smp_r);
  assign mag_nxt  = sum_r[cgrm_pkg::SUM_W-1] ? cgrm_pkg::MAG_W'(unsigned'(-sum_r))
                                              : cgrm_pkg::MAG_W'(unsigned'(sum_r));
  assign sat      = (cgrm_pkg::SAT_W'(num_r) >=
                     cgrm_pkg::SAT_W'({den_r, {cgrm_pkg::PCT_W{1'b0}}}));

  assign sts.div_busy = div_busy;
  assign sts.lvl_div  = (cnt_r != '0);
  assign sts.pct_div  = (den_r != '0) && !sat;

  // window and calibration update
  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    cal_nxt  = cal_r;
    if (cmd.update) begin
      if (cmd_r == cgrm_pkg::CMD_LOAD) begin
        cal_nxt = smp_abs;
      end else begin
        sum_nxt  = sum_r - cgrm_pkg::SUM_W'(old_smp) + cgrm_pkg::SUM_W'(smp_r);
        slot_nxt = (slot_r == cgrm_pkg::SLOT_W'(cgrm_pkg::WINDOW - 1)) ? '0
                                                                       : slot_r + 1'b1;
        cnt_nxt  = cnt_full ? cnt_r : cnt_r + 1'b1;
      end
    end else if (cmd.cal_step && (cmd_r == cgrm_pkg::CMD_CALIBRATE)) begin
      cal_nxt = lvl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= cgrm_pkg::REF_RESET;
      slot_r <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
      cal_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        ref_r <= cfg_wr_data;
      end
      slot_r <= slot_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      cal_r  <= cal_nxt;
    end
  end

  // entries past the fill count are never read
  always_ff @(posedge clk) begin
    if (cmd.update && (cmd_r != cgrm_pkg::CMD_LOAD)) begin
      win_r[slot_r] <= smp_r;
    end
  end

  // shared divider: level = |sum|/count, percent = num/den with num < den<<16
  always_comb begin
    div_ld    = 1'b0;
    div_dvd   = cgrm_pkg::NUM_W'(mag_nxt) << (cgrm_pkg::NUM_W - cgrm_pkg::MAG_W);
    div_rem   = '0;
    div_dsr   = cgrm_pkg::DEN_W'(cnt_r);
    div_steps = cgrm_pkg::STEP_W'(cgrm_pkg::MAG_W);
    if (cmd.lvl_start) begin
      div_ld = sts.lvl_div;
    end else if (cmd.pct_check) begin
      div_ld    = sts.pct_div;
      div_dvd   = num_r << (cgrm_pkg::NUM_W - cgrm_pkg::PCT_W);
      div_rem   = cgrm_pkg::DEN_W'(num_r >> cgrm_pkg::PCT_W);
      div_dsr   = den_r;
      div_steps = cgrm_pkg::STEP_W'(cgrm_pkg::PCT_W);
    end
  end

  cgrm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld     (div_ld),
    .dvd_in (div_dvd),
    .rem_in (div_rem),
    .dsr_in (div_dsr),
    .steps  (div_steps),
    .busy   (div_busy),
    .quo    (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      smp_r <= in_sample;
    end
    if (cmd.lvl_start) begin
      mag_r <= mag_nxt;
      lvl_r <= '0;
    end
    if (cmd.lvl_take) begin
      lvl_r <= div_quo[cgrm_pkg::LVL_W-1:0];
    end
    if (cmd.cal_step) begin
      mref_r <= cgrm_pkg::MREF_W'(mag_r) * cgrm_pkg::MREF_W'(ref_r);
      low_r  <= (cgrm_pkg::LOW_W'(mag_r) * cgrm_pkg::LOW_W'(cgrm_pkg::LOW_MAG_MUL)) <
                (cgrm_pkg::LOW_W'(cnt_r) * cgrm_pkg::LOW_W'(cgrm_pkg::LOW_CNT_MUL));
    end
    if (cmd.prod_step) begin
      num_r <= cgrm_pkg::NUM_W'(mref_r) * cgrm_pkg::NUM_W'(cgrm_pkg::PCT_SCALE);
      den_r <= cgrm_pkg::DEN_W'(cnt_r) * cgrm_pkg::DEN_W'(cal_r);
    end
    if (cmd.pct_check) begin
      pct_r  <= sat ? '1 : '0;
      clip_r <= sat && (den_r != '0);
    end
    if (cmd.pct_take) begin
      pct_r <= div_quo[cgrm_pkg::PCT_W-1:0];
    end
    if (cmd.out_load) begin
      out_pct_r   <= (den_r != '0) ? pct_r : '0;
      out_lvl_r   <= lvl_r;
      out_low_r   <= low_r;
      out_uncal_r <= (cal_r == '0);
      out_clip_r  <= clip_r;
    end
  end

  assign out_pct   = out_pct_r;
  assign out_lvl   = out_lvl_r;
  assign out_low   = out_low_r;
  assign out_uncal = out_uncal_r;
  assign out_clip  = out_clip_r;

endmodule

// ===== rtl/cgrm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgrm_ctrl
// Sequencer: one item through update, up to two divisions and result load.
// ----------------------------------------------------------------------------
module cgrm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  cgrm_pkg::dp_sts_t    sts,
  output cgrm_pkg::ctrl_cmd_t  cmd
);

  cgrm_pkg::state_t state_r, state_nxt;
  logic             ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cgrm_pkg::S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      cgrm_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = cgrm_pkg::S_UPDATE;
        end
      end
      cgrm_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = cgrm_pkg::S_LVL_LOAD;
      end
      cgrm_pkg::S_LVL_LOAD: begin
        cmd.lvl_start = 1'b1;
        state_nxt     = sts.lvl_div ? cgrm_pkg::S_LVL_RUN : cgrm_pkg::S_CAL;
      end
      cgrm_pkg::S_LVL_RUN: begin
        if (!sts.div_busy) begin
          cmd.lvl_take = 1'b1;
          state_nxt    = cgrm_pkg::S_CAL;
        end
      end
      cgrm_pkg::S_CAL: begin
        cmd.cal_step = 1'b1;
        state_nxt    = cgrm_pkg::S_PROD;
      end
      cgrm_pkg::S_PROD: begin
        cmd.prod_step = 1'b1;
        state_nxt     = cgrm_pkg::S_CHECK;
      end
      cgrm_pkg::S_CHECK: begin
        cmd.pct_check = 1'b1;
        state_nxt     = sts.pct_div ? cgrm_pkg::S_PCT_RUN : cgrm_pkg::S_DONE;
      end
      cgrm_pkg::S_PCT_RUN: begin
        if (!sts.div_busy) begin
          cmd.pct_take = 1'b1;
          state_nxt    = cgrm_pkg::S_DONE;
        end
      end
      cgrm_pkg::S_DONE: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = cgrm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cgrm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  assign in_tready  = (state_r == cgrm_pkg::S_IDLE);
  assign out_tvalid = ovalid_r;

endmodule

// ===== rtl/calibrated_gas_ratio_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calibrated_gas_ratio_meter
// Moving-average gas ratio meter with capture/load calibration.
// ----------------------------------------------------------------------------
// One item in flight at a time. The shared bit-serial divider runs 19 steps
// for the average level and 16 steps for the percentage. With an empty window
// the level division is skipped; with an empty window, no calibration or a
// clipped percentage the percentage division is skipped. A finished result
// sits in the output register while the next item is accepted; the sequencer
// waits in its last state only if that register is still full and not taken.
module calibrated_gas_ratio_meter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] percent_x100, [31:16] level_code
  output logic [2:0]  out_tuser,  // [0] low_signal, [1] uncalibrated, [2] clipped
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data // reference_percent_x10
);

  cgrm_pkg::ctrl_cmd_t          cmd;
  cgrm_pkg::dp_sts_t            sts;
  logic [cgrm_pkg::PCT_W-1:0]   pct;
  logic [cgrm_pkg::LVL_W-1:0]   lvl;
  logic                         low;
  logic                         uncal;
  logic                         clip;

  cgrm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cgrm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_cmd      (in_tuser),
    .in_sample   (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_pct     (pct),
    .out_lvl     (lvl),
    .out_low     (low),
    .out_uncal   (uncal),
    .out_clip    (clip)
  );

  assign out_tdata = {lvl, pct};
  assign out_tuser = {clip, uncal, low};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in work");

  a_uncal_zero_pct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata[15:0] == 16'd0 && !out_tuser[2]))
    else $error("nonzero percentage without calibration");

  a_clip_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tdata[15:0] == 16'hFFFF))
    else $error("clipped result not at full scale");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:16] <= 16'd32768))
    else $error("level above sample range");
`endif

endmodule
